// File: rtl/hlp_pkg.sv
// ----------------------------------------------------------------------------
// hlp_pkg
// shared types, constants and character tables of the request line parser
// ----------------------------------------------------------------------------
package hlp_pkg;

  // receive buffer size; bytes at or past this position end the text
  localparam int MAX_REQUEST_BYTES = 4096;
  localparam int POS_W             = $clog2(MAX_REQUEST_BYTES + 1);

  // fixed payload widths
  localparam int METHOD_W = 3;
  localparam int OFFSET_W = 12;
  localparam int LENGTH_W = 13;
  localparam int INDEX_W  = 4;
  localparam int NUM_METHODS = 8;
  localparam logic [INDEX_W-1:0] VERSION_LEN = 4'd8;
  localparam logic [INDEX_W-1:0] INDEX_MAX   = 4'd15;
  localparam logic [LENGTH_W-1:0] COUNT_MAX  = 13'h1fff;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef enum logic [1:0] {
    ST_OK                  = 2'd0,
    ST_BAD_REQUEST         = 2'd1,
    ST_VERSION_UNSUPPORTED = 2'd2
  } hlp_status_t;

  typedef enum logic [2:0] {
    M_GET     = 3'd0,
    M_POST    = 3'd1,
    M_PUT     = 3'd2,
    M_DELETE  = 3'd3,
    M_CONNECT = 3'd4,
    M_TRACE   = 3'd5,
    M_HEAD    = 3'd6,
    M_OPTIONS = 3'd7
  } hlp_method_t;

  typedef enum logic [5:0] {
    PH_METHOD    = 6'b000001,
    PH_URI_FIRST = 6'b000010,
    PH_URI       = 6'b000100,
    PH_VER_FIRST = 6'b001000,
    PH_VER       = 6'b010000,
    PH_AFTER_CR  = 6'b100000
  } hlp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } hlp_byte_t;

  typedef struct packed {
    hlp_status_t         status;
    logic [METHOD_W-1:0] method;
    logic [OFFSET_W-1:0] uri_offset;
    logic [LENGTH_W-1:0] uri_length;
  } hlp_result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DELTA : c;
  endfunction

  function automatic logic [INDEX_W-1:0] method_len(input logic [METHOD_W-1:0] m);
    logic [INDEX_W-1:0] len;
    case (m)
      M_GET:     len = 4'd3;
      M_POST:    len = 4'd4;
      M_PUT:     len = 4'd3;
      M_DELETE:  len = 4'd6;
      M_CONNECT: len = 4'd7;
      M_TRACE:   len = 4'd5;
      M_HEAD:    len = 4'd4;
      M_OPTIONS: len = 4'd7;
      default:   len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] method_char(input logic [METHOD_W-1:0] m,
                                             input logic [2:0] i);
    logic [55:0] name;
    case (m)
      M_GET:     name = {"get", 32'h0};
      M_POST:    name = {"post", 24'h0};
      M_PUT:     name = {"put", 32'h0};
      M_DELETE:  name = {"delete", 8'h0};
      M_CONNECT: name = "connect";
      M_TRACE:   name = {"trace", 16'h0};
      M_HEAD:    name = {"head", 24'h0};
      M_OPTIONS: name = "options";
      default:   name = '0;
    endcase
    // first character sits in the top byte
    return name[55 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] i);
    logic [63:0] text;
    text = "http/1.1";
    return text[63 - 8 * i -: 8];
  endfunction

endpackage

// File: rtl/hlp_if.sv
// ----------------------------------------------------------------------------
// hlp_if
// valid/ready channels for request bytes and verdicts
// ----------------------------------------------------------------------------
interface hlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hlp_verdict_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  method;
  logic [11:0] uri_offset;
  logic [12:0] uri_length;

  modport source (output valid, output status, output method, output uri_offset,
                  output uri_length, input ready);
  modport sink   (input valid, input status, input method, input uri_offset,
                  input uri_length, output ready);
endinterface

// File: rtl/hlp_core.sv
// ----------------------------------------------------------------------------
// hlp_core
// parse state and the one-byte step of the request line checker
// ----------------------------------------------------------------------------
module hlp_core import hlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  hlp_byte_t   din,
  output logic        res_valid,
  output hlp_result_t res
);

  hlp_phase_t          phase, phase_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [NUM_METHODS-1:0] cand, cand_next;
  logic [INDEX_W-1:0]  idx, idx_next;
  logic [OFFSET_W-1:0] uri_start, uri_start_next;
  logic [LENGTH_W-1:0] uri_count, uri_count_next;
  logic                ver_ok, ver_ok_next;
  logic                verdict_given, verdict_given_next;
  logic [METHOD_W-1:0] chosen, chosen_next;

  logic [7:0]             c, lc;
  logic [NUM_METHODS-1:0] hit, keep;
  logic                   vm_eff;
  logic [INDEX_W-1:0]     idx_eff;
  logic                   give;
  hlp_status_t            give_status;

  always_comb begin
    c  = din.data_byte;
    lc = to_lower(c);
    for (int k = 0; k < NUM_METHODS; k++) begin
      hit[k]  = cand[k] && (method_len(METHOD_W'(k)) == idx);
      keep[k] = (idx < method_len(METHOD_W'(k))) &&
                (method_char(METHOD_W'(k), idx[2:0]) == lc);
    end
    // the first version byte starts a fresh compare
    vm_eff  = (phase == PH_VER_FIRST) ? 1'b1 : ver_ok;
    idx_eff = (phase == PH_VER_FIRST) ? '0 : idx;

    phase_next         = phase;
    pos_next           = pos;
    cand_next          = cand;
    idx_next           = idx;
    uri_start_next     = uri_start;
    uri_count_next     = uri_count;
    ver_ok_next        = ver_ok;
    verdict_given_next = verdict_given;
    chosen_next        = chosen;
    give               = 1'b0;
    give_status        = ST_BAD_REQUEST;

    if (!verdict_given) begin
      if (c == CH_NUL || pos >= POS_W'(MAX_REQUEST_BYTES)) begin
        give = 1'b1;
      end else begin
        case (phase)
          PH_METHOD: begin
            if (c == CH_SPACE) begin
              if (|hit) begin
                for (int k = NUM_METHODS - 1; k >= 0; k--) begin
                  if (hit[k]) chosen_next = METHOD_W'(k);
                end
                phase_next = PH_URI_FIRST;
              end else begin
                give = 1'b1;
              end
            end else begin
              cand_next = cand & keep;
              if (idx < INDEX_MAX) idx_next = idx + 1'b1;
            end
          end
          PH_URI_FIRST: begin
            if (c == CH_SPACE) begin
              give = 1'b1;
            end else begin
              uri_start_next = pos[OFFSET_W-1:0];
              uri_count_next = LENGTH_W'(1);
              phase_next     = PH_URI;
            end
          end
          PH_URI: begin
            if (c == CH_SPACE) begin
              phase_next = PH_VER_FIRST;
            end else if (uri_count < COUNT_MAX) begin
              uri_count_next = uri_count + 1'b1;
            end
          end
          PH_VER_FIRST, PH_VER: begin
            if (phase == PH_VER_FIRST && c == CH_SPACE) begin
              give = 1'b1;
            end else begin
              phase_next  = PH_VER;
              ver_ok_next = vm_eff;
              idx_next    = idx_eff;
              if (c == CH_CR) begin
                phase_next = PH_AFTER_CR;
              end else if (c == CH_LF) begin
                give        = 1'b1;
                give_status = (vm_eff && idx_eff == VERSION_LEN) ? ST_OK
                                                                 : ST_VERSION_UNSUPPORTED;
              end else begin
                if (idx_eff[3] || version_char(idx_eff[2:0]) != lc) ver_ok_next = 1'b0;
                if (idx_eff < INDEX_MAX) idx_next = idx_eff + 1'b1;
              end
            end
          end
          PH_AFTER_CR: begin
            give = 1'b1;
            if (c == CH_LF) begin
              give_status = (ver_ok && idx == VERSION_LEN) ? ST_OK : ST_VERSION_UNSUPPORTED;
            end
          end
          default: give = 1'b1;
        endcase
        pos_next = pos + 1'b1;
        // last byte with the line still open
        if (!give && din.last) give = 1'b1;
      end
    end
    if (give) verdict_given_next = 1'b1;

    // end of request buffer: back to the reset state
    if (din.last) begin
      phase_next         = PH_METHOD;
      pos_next           = '0;
      cand_next          = '1;
      idx_next           = '0;
      uri_start_next     = '0;
      uri_count_next     = '0;
      ver_ok_next        = 1'b1;
      verdict_given_next = 1'b0;
      chosen_next        = '0;
    end

    res_valid      = give;
    res.status     = give_status;
    res.method     = (give_status == ST_OK) ? chosen : '0;
    res.uri_offset = (give_status == ST_OK) ? uri_start : '0;
    res.uri_length = (give_status == ST_OK) ? uri_count : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_METHOD;
      pos           <= '0;
      cand          <= '1;
      idx           <= '0;
      uri_start     <= '0;
      uri_count     <= '0;
      ver_ok        <= 1'b1;
      verdict_given <= 1'b0;
      chosen        <= '0;
    end else if (step) begin
      phase         <= phase_next;
      pos           <= pos_next;
      cand          <= cand_next;
      idx           <= idx_next;
      uri_start     <= uri_start_next;
      uri_count     <= uri_count_next;
      ver_ok        <= ver_ok_next;
      verdict_given <= verdict_given_next;
      chosen        <= chosen_next;
    end
  end

endmodule

// File: rtl/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// http_request_line_parser
// checks the request line of one received http request, one byte per request
// ----------------------------------------------------------------------------
// Bytes of a received request arrive on rx, one per request, with last set on
// the final byte of the buffer. The block checks method, one space, uri, one
// space, version and then LF or CR LF, and puts out exactly one verdict per
// request on the verdict channel: ok with method code, uri offset and uri
// length, bad request, or version not supported. Method names and the version
// are matched without regard to ascii case. A zero byte, a byte at position
// 4096 or beyond, or the last byte with the line still open ends the text
// with bad request. Bytes after the verdict are dropped up to the last one.
// Throughput is one byte per clock while the verdict channel is not stalled;
// a byte's verdict passes the input register, then the result register,
// before it shows on the verdict channel. The parse step only advances while
// the result register is free or being emptied, so a stalled verdict stalls rx
// once the input register holds a byte.
// ----------------------------------------------------------------------------
module http_request_line_parser import hlp_pkg::*; (
  input logic            clk,
  input logic            rst,
  hlp_byte_if.sink       rx,
  hlp_verdict_if.source  verdict
);

  // input register
  logic      in_valid;
  hlp_byte_t in_data;

  // result register
  logic        out_valid;
  hlp_result_t out_data;

  logic        out_free;
  logic        step;
  logic        res_valid;
  hlp_result_t res;

  // result slot empty or emptied this cycle
  assign out_free = !out_valid || verdict.ready;
  // the buffered byte moves through the parse step
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_data.data_byte <= rx.data_byte;
      in_data.last      <= rx.last;
    end
  end

  hlp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .din       (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      out_data <= res;
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.status     = out_data.status;
  assign verdict.method     = out_data.method;
  assign verdict.uri_offset = out_data.uri_offset;
  assign verdict.uri_length = out_data.uri_length;

endmodule

// File: rtl/hlp_checker.sv
// ----------------------------------------------------------------------------
// hlp_checker
// port-level checks on the verdict channel of the request line parser
// ----------------------------------------------------------------------------
module hlp_checker import hlp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [2:0]  method,
  input logic [11:0] uri_offset,
  input logic [12:0] uri_length
);

  // a failed request carries no method or uri
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> method == '0 && uri_offset == '0 && uri_length == '0)
    else $error("failed verdict carries method or uri data");

  // an accepted line always has at least one uri byte
  a_ok_uri: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> uri_length != '0)
    else $error("ok verdict with empty uri");

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_BAD_REQUEST ||
                  status == ST_VERSION_UNSUPPORTED)
    else $error("undefined status code");

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(method) &&
                                $stable(uri_offset) && $stable(uri_length))
    else $error("stalled verdict changed");

endmodule

bind http_request_line_parser hlp_checker u_hlp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (verdict.valid),
  .out_ready  (verdict.ready),
  .status     (verdict.status),
  .method     (verdict.method),
  .uri_offset (verdict.uri_offset),
  .uri_length (verdict.uri_length)
);
